// File: hdl/drlr_pkg.sv
`timescale 1ns / 1ps
package drlr_pkg;

    localparam int MAX_TOKENS = 64;
    localparam int IDX_W      = $clog2(MAX_TOKENS);
    localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
    localparam int DUR_W      = 16;
    localparam int TGT_W      = 24;
    localparam int TOT_W      = 22;
    localparam int PROD_W     = TGT_W + DUR_W;
    localparam int SUM_W      = TGT_W + IDX_W + 1;
    localparam int BIT_W      = $clog2(PROD_W + 1);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_LOAD, S_CHECK, S_RD, S_MUL, S_DIV, S_WR, S_DIFF,
        S_SC_RD, S_SC_CMP, S_PICK, S_EM_RD, S_EM_OUT, S_ERR
    } t_state;

    typedef struct packed {
        logic load;
        logic chk;
        logic rd;
        logic mul;
        logic div;
        logic wr;
        logic diff;
        logic sc_rd;
        logic sc_cmp;
        logic pick;
        logic em_rd;
        logic em_next;
        logic clr;
    } t_cmd;

    typedef struct packed {
        logic in_last;
        logic err;
        logic div_done;
        logic idx_last;
        logic diff_zero;
        logic j_last;
        logic pk_last;
    } t_stat;

endpackage

// File: hdl/drlr_if.sv
`timescale 1ns / 1ps
interface drlr_in_if;
    logic                          valid;
    logic                          ready;
    logic [drlr_pkg::DUR_W-1:0]    duration;
    logic                          last;
    modport source (output valid, output duration, output last, input ready);
    modport sink   (input valid, input duration, input last, output ready);
endinterface

interface drlr_out_if;
    logic                          valid;
    logic                          ready;
    logic [drlr_pkg::TGT_W-1:0]    scaled_duration;
    logic [drlr_pkg::IDX_W-1:0]    token_index;
    logic                          last_result;
    logic [1:0]                    status;
    modport source (output valid, output scaled_duration, output token_index,
                    output last_result, output status, input ready);
    modport sink   (input valid, input scaled_duration, input token_index,
                    input last_result, input status, output ready);
endinterface

interface drlr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [drlr_pkg::TGT_W-1:0]    target_total;
    modport source (output valid, output target_total, input ready);
    modport sink   (input valid, input target_total, output ready);
endinterface

// File: hdl/drlr_datapath.sv
`timescale 1ns / 1ps
module drlr_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [drlr_pkg::TGT_W-1:0]    i_cfg_target,
    input  logic [drlr_pkg::DUR_W-1:0]    i_duration,
    input  logic                          i_last,
    input  drlr_pkg::t_cmd                i_cmd,
    output drlr_pkg::t_stat               o_stat,
    output logic [drlr_pkg::TGT_W-1:0]    o_scaled,
    output logic [drlr_pkg::IDX_W-1:0]    o_index,
    output logic                          o_last_result,
    output logic [1:0]                    o_status
);

    logic [drlr_pkg::DUR_W-1:0]  mem_d [drlr_pkg::MAX_TOKENS];
    logic [drlr_pkg::TOT_W-1:0]  mem_r [drlr_pkg::MAX_TOKENS];
    logic [drlr_pkg::TGT_W-1:0]  mem_s [drlr_pkg::MAX_TOKENS];

    logic [drlr_pkg::TGT_W-1:0]  r_target;
    logic [drlr_pkg::CNT_W-1:0]  r_count;
    logic [drlr_pkg::TOT_W-1:0]  r_total;
    logic                        r_ovf;
    drlr_pkg::t_status           r_err;
    logic                        r_shrink;
    logic [drlr_pkg::IDX_W-1:0]  r_idx;
    logic [drlr_pkg::IDX_W-1:0]  r_j;
    logic [drlr_pkg::DUR_W-1:0]  r_d;
    logic [drlr_pkg::PROD_W-1:0] r_dv;
    logic [drlr_pkg::TOT_W-1:0]  r_rem;
    logic [drlr_pkg::BIT_W-1:0]  r_bit;
    logic [drlr_pkg::SUM_W-1:0]  r_sum;
    logic [drlr_pkg::CNT_W-1:0]  r_pk;
    logic [drlr_pkg::MAX_TOKENS-1:0] r_picked;
    logic [drlr_pkg::TOT_W-1:0]  r_rv;
    logic [drlr_pkg::TOT_W-1:0]  r_best_r;
    logic [drlr_pkg::IDX_W-1:0]  r_best;
    logic                        r_found;
    logic [drlr_pkg::TGT_W-1:0]  r_sv;

    logic [drlr_pkg::TOT_W:0]    n_rem2;
    logic                        n_ge;
    logic [drlr_pkg::TOT_W-1:0]  n_rem;
    logic [drlr_pkg::TGT_W-1:0]  n_q;
    logic [drlr_pkg::TOT_W-1:0]  n_r;
    logic [drlr_pkg::SUM_W-1:0]  n_diff;
    logic                        n_cand;
    logic [drlr_pkg::IDX_W-1:0]  n_last_idx;

    assign n_last_idx = drlr_pkg::IDX_W'(r_count - drlr_pkg::CNT_W'(1));

    always_comb begin
        n_rem2 = {r_rem, r_dv[drlr_pkg::PROD_W-1]};
        n_ge   = (n_rem2 >= {1'b0, r_total});
        n_rem  = n_ge ? drlr_pkg::TOT_W'(n_rem2 - {1'b0, r_total})
                      : drlr_pkg::TOT_W'(n_rem2);
        n_q    = r_dv[drlr_pkg::TGT_W-1:0];
        n_r    = r_rem;
        if (r_shrink && (r_rem != '0)) begin
            n_q = n_q + drlr_pkg::TGT_W'(1);
            n_r = r_total - r_rem;
        end
        n_diff = r_shrink ? r_sum - drlr_pkg::SUM_W'(r_target)
                          : drlr_pkg::SUM_W'(r_target) - r_sum;
        n_cand = !r_picked[r_j] && (!r_found || (r_rv >= r_best_r));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_count  <= '0;
            r_total  <= '0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_target;
            end
            if (i_cmd.load) begin
                if (r_count < drlr_pkg::CNT_W'(drlr_pkg::MAX_TOKENS)) begin
                    r_count <= r_count + drlr_pkg::CNT_W'(1);
                    r_total <= r_total + drlr_pkg::TOT_W'(i_duration);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.clr) begin
                r_count <= '0;
                r_total <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < drlr_pkg::CNT_W'(drlr_pkg::MAX_TOKENS))) begin
            mem_d[r_count[drlr_pkg::IDX_W-1:0]] <= i_duration;
        end
        if (i_cmd.wr) begin
            mem_s[r_idx] <= n_q;
            mem_r[r_idx] <= n_r;
        end
        if (i_cmd.rd) begin
            r_d <= mem_d[r_idx];
        end
        if (i_cmd.sc_rd) begin
            r_rv <= mem_r[r_j];
        end
        if (i_cmd.em_rd) begin
            r_sv <= mem_s[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.chk) begin
            r_err    <= r_ovf ? drlr_pkg::ST_OVF
                      : (r_total == '0) ? drlr_pkg::ST_ZERO : drlr_pkg::ST_OK;
            r_shrink <= (drlr_pkg::TOT_W'(0) != r_total) &&
                        ({{(drlr_pkg::TGT_W-drlr_pkg::TOT_W){1'b0}}, r_total} > r_target);
            r_idx    <= '0;
            r_sum    <= '0;
        end
        if (i_cmd.mul) begin
            r_dv  <= r_target * r_d;
            r_rem <= '0;
            r_bit <= drlr_pkg::BIT_W'(drlr_pkg::PROD_W);
        end
        if (i_cmd.div) begin
            r_dv  <= {r_dv[drlr_pkg::PROD_W-2:0], n_ge};
            r_rem <= n_rem;
            r_bit <= r_bit - drlr_pkg::BIT_W'(1);
        end
        if (i_cmd.wr) begin
            r_sum <= r_sum + drlr_pkg::SUM_W'(n_q);
            r_idx <= r_idx + drlr_pkg::IDX_W'(1);
        end
        if (i_cmd.diff) begin
            r_pk     <= drlr_pkg::CNT_W'(n_diff);
            r_picked <= '0;
            r_idx    <= '0;
            r_j      <= '0;
            r_found  <= 1'b0;
        end
        if (i_cmd.sc_cmp) begin
            r_j <= r_j + drlr_pkg::IDX_W'(1);
            if (n_cand) begin
                r_best   <= r_j;
                r_best_r <= r_rv;
                r_found  <= 1'b1;
            end
        end
        if (i_cmd.pick) begin
            r_picked[r_best] <= 1'b1;
            r_pk    <= r_pk - drlr_pkg::CNT_W'(1);
            r_j     <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.em_next) begin
            r_idx <= r_idx + drlr_pkg::IDX_W'(1);
        end
    end

    always_comb begin
        o_stat.in_last   = i_last;
        o_stat.err       = r_ovf || (r_total == '0);
        o_stat.div_done  = (r_bit == drlr_pkg::BIT_W'(1));
        o_stat.idx_last  = (r_idx == n_last_idx);
        o_stat.diff_zero = (drlr_pkg::CNT_W'(n_diff) == '0);
        o_stat.j_last    = (r_j == n_last_idx);
        o_stat.pk_last   = (r_pk == drlr_pkg::CNT_W'(1));
    end

    always_comb begin
        if (r_err != drlr_pkg::ST_OK) begin
            o_scaled      = '0;
            o_index       = '0;
            o_last_result = 1'b1;
        end else begin
            o_scaled = r_sv;
            if (r_picked[r_idx]) begin
                if (!r_shrink) begin
                    o_scaled = r_sv + drlr_pkg::TGT_W'(1);
                end else if (r_sv != '0) begin
                    o_scaled = r_sv - drlr_pkg::TGT_W'(1);
                end
            end
            o_index       = r_idx;
            o_last_result = (r_idx == n_last_idx);
        end
        o_status = r_err;
    end

endmodule

// File: hdl/drlr_ctrl.sv
`timescale 1ns / 1ps
module drlr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  drlr_pkg::t_stat  i_stat,
    output drlr_pkg::t_cmd   o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);

    drlr_pkg::t_state r_state;
    drlr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drlr_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            drlr_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.in_last) n_state = drlr_pkg::S_CHECK;
                end
            end
            drlr_pkg::S_CHECK: begin
                o_cmd.chk = 1'b1;
                n_state = i_stat.err ? drlr_pkg::S_ERR : drlr_pkg::S_RD;
            end
            drlr_pkg::S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = drlr_pkg::S_MUL;
            end
            drlr_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = drlr_pkg::S_DIV;
            end
            drlr_pkg::S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_stat.div_done) n_state = drlr_pkg::S_WR;
            end
            drlr_pkg::S_WR: begin
                o_cmd.wr = 1'b1;
                n_state = i_stat.idx_last ? drlr_pkg::S_DIFF : drlr_pkg::S_RD;
            end
            drlr_pkg::S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = i_stat.diff_zero ? drlr_pkg::S_EM_RD : drlr_pkg::S_SC_RD;
            end
            drlr_pkg::S_SC_RD: begin
                o_cmd.sc_rd = 1'b1;
                n_state = drlr_pkg::S_SC_CMP;
            end
            drlr_pkg::S_SC_CMP: begin
                o_cmd.sc_cmp = 1'b1;
                n_state = i_stat.j_last ? drlr_pkg::S_PICK : drlr_pkg::S_SC_RD;
            end
            drlr_pkg::S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state = i_stat.pk_last ? drlr_pkg::S_EM_RD : drlr_pkg::S_SC_RD;
            end
            drlr_pkg::S_EM_RD: begin
                o_cmd.em_rd = 1'b1;
                n_state = drlr_pkg::S_EM_OUT;
            end
            drlr_pkg::S_EM_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.em_next = 1'b1;
                    if (i_stat.idx_last) begin
                        o_cmd.clr = 1'b1;
                        n_state = drlr_pkg::S_LOAD;
                    end else begin
                        n_state = drlr_pkg::S_EM_RD;
                    end
                end
            end
            drlr_pkg::S_ERR: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.clr = 1'b1;
                    n_state = drlr_pkg::S_LOAD;
                end
            end
            default: n_state = drlr_pkg::S_LOAD;
        endcase
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output open together");

    a_last_stops_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_stat.in_last) |=> !o_in_ready)
        else $error("load continued after last transfer");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.div, o_cmd.wr, o_cmd.pick, o_cmd.sc_cmp}))
        else $error("conflicting datapath commands");

endmodule

// File: hdl/duration_rescale_largest_remainder.sv
`timescale 1ns / 1ps
// Loads up to 64 durations, one per cycle, then rescales them to sum to target_total
// with largest-remainder correction. Per token, the duration is read, multiplied by the
// target and divided by a 40-step bit-serial divider. Correction makes diff passes
// (diff < n) over all n remainders; each result is read, then held until accepted.
// Error runs give one result. No input is taken while a run is computed or emitted.
module duration_rescale_largest_remainder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    drlr_cfg_if.sink     i_cfg,
    drlr_in_if.sink      i_dur,
    drlr_out_if.source   o_res
);

    drlr_pkg::t_cmd  w_cmd;
    drlr_pkg::t_stat w_stat;

    assign i_cfg.ready = 1'b1;

    drlr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_dur.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_ready  (i_dur.ready),
        .o_out_valid (o_res.valid)
    );

    drlr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_target  (i_cfg.target_total),
        .i_duration    (i_dur.duration),
        .i_last        (i_dur.last),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_scaled      (o_res.scaled_duration),
        .o_index       (o_res.token_index),
        .o_last_result (o_res.last_result),
        .o_status      (o_res.status)
    );

endmodule
